[rtl/kssr_pkg.sv]
// kssr_pkg: shared types and constants of the key set swap-remove unit
// used by kssr_front, kssr_back, kssr_resq and key_set_swap_remove_unit
// no dependencies
`default_nettype none

package kssr_pkg;

  localparam int unsigned CAPACITY_DEF = 1024;
  localparam int unsigned KEY_W        = 32;

  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STAT_DONE = 2'd0,
    STAT_MISS = 2'd1,
    STAT_FULL = 2'd2
  } status_e;

  // classified command handed from front to back
  typedef struct packed {
    op_e                     op;
    logic signed [KEY_W-1:0] key;
  } cmd_t;

  // handshake between back and result queue
  typedef struct packed {
    logic full;
  } resq_ctl_t;

endpackage

`default_nettype wire

[rtl/kssr_front.sv]
// kssr_front: accepts input words, classifies the operation, and holds
// them in a two-entry command queue for the back end
// depends on kssr_pkg
`default_nettype none

module kssr_front (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             push,
  output logic                                  full,
  input  wire logic                             operation_i,
  input  wire logic signed [kssr_pkg::KEY_W-1:0] key_i,
  output logic                                  cmd_valid_o,
  output kssr_pkg::cmd_t                        cmd_o,
  input  wire logic                             cmd_pop_i
);
  import kssr_pkg::*;

  cmd_t        slot_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  fill_q, fill_d;
  logic        do_push, do_pop;
  cmd_t        cmd_in;

  assign full        = (fill_q == 2'd2);
  assign cmd_valid_o = (fill_q != 2'd0);
  assign cmd_o       = slot_q[rd_ptr_q];

  assign do_push = push && !full;
  assign do_pop  = cmd_pop_i && cmd_valid_o;

  always_comb begin
    cmd_in.op  = operation_i ? OP_REMOVE : OP_APPEND;
    cmd_in.key = key_i;
  end

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop  ? !rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q;
    if (do_push && !do_pop) begin
      fill_d = fill_q + 2'd1;
    end else if (!do_push && do_pop) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

[rtl/kssr_resq.sv]
// kssr_resq: two-entry result queue between the back end and the result port
// depends on kssr_pkg
`default_nettype none

module kssr_resq #(
  parameter int unsigned CNT_W = 11
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  output kssr_pkg::resq_ctl_t     ctl_o,
  input  wire logic               push_i,
  input  wire kssr_pkg::status_e  status_i,
  input  wire logic [CNT_W-1:0]   count_i,
  input  wire logic               sorted_i,
  output logic                    empty,
  input  wire logic               pop,
  output logic [1:0]              status_o,
  output logic [CNT_W-1:0]        count_o,
  output logic                    sorted_o
);
  import kssr_pkg::*;

  typedef struct packed {
    status_e          status;
    logic [CNT_W-1:0] count;
    logic             sorted;
  } res_t;

  res_t        slot_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  fill_q, fill_d;
  logic        do_push, do_pop;
  res_t        res_in;
  res_t        res_out;

  assign res_in = '{status: status_i, count: count_i, sorted: sorted_i};

  assign ctl_o.full = (fill_q == 2'd2);
  assign empty      = (fill_q == 2'd0);
  assign do_push    = push_i && !ctl_o.full;
  assign do_pop     = pop && !empty;

  assign res_out  = slot_q[rd_ptr_q];
  assign status_o = res_out.status;
  assign count_o  = res_out.count;
  assign sorted_o = res_out.sorted;

  always_comb begin
    fill_d = fill_q;
    if (do_push && !do_pop) begin
      fill_d = fill_q + 2'd1;
    end else if (!do_push && do_pop) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop)  rd_ptr_q <= !rd_ptr_q;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= res_in;
    end
  end

endmodule

`default_nettype wire

[rtl/kssr_back.sv]
// kssr_back: executes append and remove commands against the key memory
// scan engine, swap write, tail refresh, count and sorted flag
// depends on kssr_pkg
`default_nettype none

module kssr_back #(
  parameter int unsigned CAPACITY = kssr_pkg::CAPACITY_DEF,
  parameter int unsigned CNT_W    = $clog2(CAPACITY + 1)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cmd_valid_i,
  input  wire kssr_pkg::cmd_t      cmd_i,
  output logic                     cmd_pop_o,
  input  wire kssr_pkg::resq_ctl_t resq_i,
  output logic                     res_push_o,
  output kssr_pkg::status_e        res_status_o,
  output logic [CNT_W-1:0]         res_count_o,
  output logic                     res_sorted_o
);
  import kssr_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_SCAN    = 6'b000010,
    S_WRITE   = 6'b000100,
    S_MISS    = 6'b001000,
    S_TAIL_RD = 6'b010000,
    S_TAIL_LD = 6'b100000
  } eng_state_e;

  eng_state_e              state_q, state_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic                    sorted_q, sorted_d;
  logic signed [KEY_W-1:0] tail_q, tail_d;
  logic signed [KEY_W-1:0] key_q, key_d;
  logic [CNT_W-1:0]        scan_idx_q, scan_idx_d;
  logic                    cmp_valid_q, cmp_valid_d;
  logic [AW-1:0]           cmp_idx_q, cmp_idx_d;
  logic [AW-1:0]           hit_idx_q, hit_idx_d;

  logic [KEY_W-1:0]        key_store_q [CAPACITY];
  logic [KEY_W-1:0]        rdata_q;
  logic [AW-1:0]           rd_addr;
  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  logic [KEY_W-1:0]        wr_data;
  logic [CNT_W-1:0]        last_idx;
  logic                    hit;

  assign last_idx = count_q - CNT_W'(1);
  assign hit      = cmp_valid_q && (rdata_q == key_q);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    sorted_d     = sorted_q;
    tail_d       = tail_q;
    key_d        = key_q;
    scan_idx_d   = scan_idx_q;
    cmp_valid_d  = 1'b0;
    cmp_idx_d    = cmp_idx_q;
    hit_idx_d    = hit_idx_q;
    cmd_pop_o    = 1'b0;
    res_push_o   = 1'b0;
    res_status_o = STAT_DONE;
    wr_en        = 1'b0;
    wr_addr      = count_q[AW-1:0];
    wr_data      = cmd_i.key;
    rd_addr      = scan_idx_q[AW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && !resq_i.full) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.op == OP_APPEND) begin
            res_push_o = 1'b1;
            if (count_q == CNT_W'(CAPACITY)) begin
              res_status_o = STAT_FULL;
            end else begin
              if ((count_q != '0) && (tail_q > cmd_i.key)) begin
                sorted_d = 1'b0;
              end
              wr_en   = 1'b1;
              tail_d  = cmd_i.key;
              count_d = count_q + CNT_W'(1);
            end
          end else begin
            key_d      = cmd_i.key;
            scan_idx_d = '0;
            state_d    = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (hit) begin
          hit_idx_d = cmp_idx_q;
          state_d   = S_WRITE;
        end else if (scan_idx_q == count_q) begin
          state_d = S_MISS;
        end else begin
          cmp_valid_d = 1'b1;
          cmp_idx_d   = scan_idx_q[AW-1:0];
          scan_idx_d  = scan_idx_q + CNT_W'(1);
        end
      end

      S_WRITE: begin
        if (!resq_i.full) begin
          wr_en      = 1'b1;
          wr_addr    = hit_idx_q;
          wr_data    = tail_q;
          count_d    = last_idx;
          res_push_o = 1'b1;
          state_d    = (last_idx == '0) ? S_IDLE : S_TAIL_RD;
        end
      end

      S_MISS: begin
        if (!resq_i.full) begin
          res_push_o   = 1'b1;
          res_status_o = STAT_MISS;
          state_d      = S_IDLE;
        end
      end

      S_TAIL_RD: begin
        rd_addr = last_idx[AW-1:0];
        state_d = S_TAIL_LD;
      end

      S_TAIL_LD: begin
        tail_d  = rdata_q;
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign res_count_o  = count_d;
  assign res_sorted_o = sorted_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      sorted_q    <= 1'b1;
      cmp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      sorted_q    <= sorted_d;
      cmp_valid_q <= cmp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tail_q     <= tail_d;
    key_q      <= key_d;
    scan_idx_q <= scan_idx_d;
    cmp_idx_q  <= cmp_idx_d;
    hit_idx_q  <= hit_idx_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_store_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= key_store_q[rd_addr];
  end

endmodule

`default_nettype wire

[rtl/key_set_swap_remove_unit.sv]
// key_set_swap_remove_unit: top level of the key set with swap remove
// depends on kssr_pkg, kssr_front, kssr_back, kssr_resq
// usage
//   input side is a queue: operation_i and key_i with push high are taken at
//   an edge where full is low; operation 0 appends the key, operation 1
//   removes the first equal entry by moving the last entry into its place
//   result side: while empty is low the oldest result sits on status_o,
//   count_o and sorted_o and leaves at an edge with pop high; one result
//   word per input word, in order
// timing
//   two-entry command queue in front, two-entry result queue behind
//   append: S_IDLE pops the command and pushes its result in the same cycle
//   remove: the single read port gives one read per cycle as S_SCAN walks up from index 0;
//   a hit goes to S_WRITE (tail into the hit slot), then, if entries remain, to S_TAIL_RD
//   and S_TAIL_LD; a miss goes to S_MISS; the next command waits for S_IDLE
// reset: asynchronous, active low; count 0, sorted 1, queues empty, key
//   memory not cleared since only entries below the count are read
// stall: with pop low the result queue fills, the engine waits, then the
//   command queue fills and full rises
`default_nettype none

module key_set_swap_remove_unit #(
  parameter int unsigned CAPACITY = kssr_pkg::CAPACITY_DEF,
  parameter int unsigned CNT_W    = $clog2(CAPACITY + 1)
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // input queue side
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic                              operation_i,
  input  wire logic signed [kssr_pkg::KEY_W-1:0] key_i,
  // result queue side
  output logic                                   empty,
  input  wire logic                              pop,
  output logic [1:0]                             status_o,
  output logic [CNT_W-1:0]                       count_o,
  output logic                                   sorted_o
);
  import kssr_pkg::*;

  // front to back command channel
  logic      cmd_valid;
  cmd_t      cmd;
  logic      cmd_pop;

  // back to result queue
  resq_ctl_t        resq_ctl;
  logic             res_push;
  status_e          res_status;
  logic [CNT_W-1:0] res_count;
  logic             res_sorted;

  // front: takes words, decodes the operation, queues commands
  kssr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .operation_i (operation_i),
    .key_i       (key_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // back: owns the key memory, count and sorted flag
  kssr_back #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd),
    .cmd_pop_o    (cmd_pop),
    .resq_i       (resq_ctl),
    .res_push_o   (res_push),
    .res_status_o (res_status),
    .res_count_o  (res_count),
    .res_sorted_o (res_sorted)
  );

  // result queue decouples the engine from a stalling receiver
  kssr_resq #(
    .CNT_W (CNT_W)
  ) u_resq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_o    (resq_ctl),
    .push_i   (res_push),
    .status_i (res_status),
    .count_i  (res_count),
    .sorted_i (res_sorted),
    .empty    (empty),
    .pop      (pop),
    .status_o (status_o),
    .count_o  (count_o),
    .sorted_o (sorted_o)
  );

endmodule

`default_nettype wire

[test/kssr_checker.sv]
`timescale 1ns / 1ps
// kssr_checker: mirrors the key store of key_set_swap_remove_unit and checks each result word
// depends on kssr_pkg; taps both queue sides of the unit, reports failures and open words

module kssr_checker #(
  parameter int unsigned CAPACITY = kssr_pkg::CAPACITY_DEF,
  parameter int unsigned CNT_W    = $clog2(CAPACITY + 1)
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              push,
  input  wire logic                              full,
  input  wire logic                              operation_i,
  input  wire logic signed [kssr_pkg::KEY_W-1:0] key_i,
  input  wire logic                              empty,
  input  wire logic                              pop,
  input  wire logic [1:0]                        status_i,
  input  wire logic [CNT_W-1:0]                  count_i,
  input  wire logic                              sorted_i,
  output int                                     fail_cnt_o,
  output int                                     pending_o
);

  typedef struct packed {
    kssr_pkg::status_e status;
    logic [CNT_W-1:0]  count;
    logic              sorted;
  } key_result_t;

  logic signed [kssr_pkg::KEY_W-1:0] key_mirror [CAPACITY];
  int unsigned                       stored;
  logic                              in_order;
  key_result_t                       due_results [$];
  int                                fails;

  function automatic key_result_t apply_key_op(kssr_pkg::op_e op,
                                               logic signed [kssr_pkg::KEY_W-1:0] key);
    key_result_t res;
    int unsigned idx;
    bit          hit;
    res.status = kssr_pkg::STAT_DONE;
    hit        = 1'b0;
    if (op == kssr_pkg::OP_APPEND) begin
      if (stored >= CAPACITY) begin
        res.status = kssr_pkg::STAT_FULL;
      end else begin
        // compared with the current tail, which a swap may have replaced
        if (stored > 0 && key_mirror[stored-1] > key) in_order = 1'b0;
        key_mirror[stored] = key;
        stored++;
      end
    end else begin
      for (idx = 0; idx < stored && !hit; idx++) begin
        if (key_mirror[idx] == key) begin
          key_mirror[idx] = key_mirror[stored-1];
          hit = 1'b1;
        end
      end
      if (hit) stored--;
      else res.status = kssr_pkg::STAT_MISS;
    end
    res.count  = CNT_W'(stored);
    res.sorted = in_order;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    key_result_t want;
    if (!rst_ni) begin
      stored   = 0;
      in_order = 1'b1;
      fails    = 0;
      due_results.delete();
      fail_cnt_o <= 0;
      pending_o  <= 0;
    end else begin
      if (pop && !empty) begin
        if (due_results.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: unexpected result word: status %0d count %0d sorted %0d",
                     $realtime, status_i, count_i, sorted_i);
        end else begin
          want = due_results.pop_front();
          if (status_i !== want.status || count_i !== want.count ||
              sorted_i !== want.sorted) begin
            fails++;
            if (fails <= 10)
              $display("%0t: mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
                       $realtime, want.status, want.count, want.sorted,
                       status_i, count_i, sorted_i);
          end
        end
      end
      if (push && !full)
        due_results.insert(due_results.size(),
                           apply_key_op(kssr_pkg::op_e'(operation_i), key_i));
      fail_cnt_o <= fails;
      pending_o  <= due_results.size();
    end
  end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// tb: stimulus and verdict for key_set_swap_remove_unit
// depends on kssr_pkg, key_set_swap_remove_unit and kssr_checker

module tb;
  import kssr_pkg::*;

  localparam int unsigned CAPACITY     = CAPACITY_DEF;
  localparam int unsigned CNT_W        = $clog2(CAPACITY + 1);
  localparam int unsigned RANDOM_WORDS = 420;
  // appends only, so the store grows and later scans get long
  localparam int unsigned GROW_WORDS   = 120;
  localparam int unsigned DEEP_WORDS   = 20;
  localparam int unsigned HOLD_CYCLES  = 80;
  // a remove on a full store scans all CAPACITY entries; the limit sits well above that
  localparam int unsigned STALL_LIMIT  = 6000;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    push;
  logic                    full;
  logic                    operation_i;
  logic signed [KEY_W-1:0] key_i;
  logic                    empty;
  logic                    pop;
  logic [1:0]              status_o;
  logic [CNT_W-1:0]        count_o;
  logic                    sorted_o;

  int                      fail_cnt;
  int                      pending;
  int unsigned             idle_cycles = 0;
  int unsigned             rx_words = 0;
  bit                      tx_calm;
  bit                      rx_calm;
  // small pool of keys so that removes hit and duplicates pile up
  logic signed [KEY_W-1:0] key_pool [16];

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  key_set_swap_remove_unit #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .operation_i(operation_i),
    .key_i      (key_i),
    .empty      (empty),
    .pop        (pop),
    .status_o   (status_o),
    .count_o    (count_o),
    .sorted_o   (sorted_o)
  );

  kssr_checker #(
    .CAPACITY(CAPACITY)
  ) key_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .operation_i(operation_i),
    .key_i      (key_i),
    .empty      (empty),
    .pop        (pop),
    .status_i   (status_o),
    .count_i    (count_o),
    .sorted_i   (sorted_o),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  // watchdog: a long stretch with no word moving on either side means a hang
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // offer one word and hold it until the unit takes it
  task automatic offer_word(op_e op, logic signed [KEY_W-1:0] key);
    int unsigned gap;
    gap = tx_calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push        <= 1'b1;
    operation_i <= op;
    key_i       <= key;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  // result side: random pop gaps, calm stretches, and two long hold-offs
  // that let both queues fill so full rises while words keep coming
  initial begin : rx_side
    int unsigned gap;
    wait (rst_ni === 1'b1);
    forever begin
      if (rx_words % 40 == 0) rx_calm = ($urandom_range(0, 2) == 0);
      gap = rx_calm ? 0 : $urandom_range(0, 3);
      if (rx_words == 60 || rx_words == 450) gap = HOLD_CYCLES;
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
      rx_words++;
    end
  end

  initial begin
    int unsigned             n;
    op_e                     op;
    logic signed [KEY_W-1:0] k;
    rst_ni      = 1'b0;
    push        = 1'b0;
    pop         = 1'b0;
    operation_i = 1'b0;
    key_i       = '0;
    tx_calm     = 1'b0;
    foreach (key_pool[i]) key_pool[i] = $urandom;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hffff_ffff;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // remove from an empty store misses
    offer_word(OP_REMOVE, 32'h0000_0000);
    // non-decreasing appends with equal neighbors and both key extremes
    offer_word(OP_APPEND, 32'h8000_0000);
    offer_word(OP_APPEND, 32'h8000_0000);
    offer_word(OP_APPEND, 32'hffff_ffff);
    offer_word(OP_APPEND, 32'h0000_0000);
    offer_word(OP_APPEND, 32'h0000_0001);
    offer_word(OP_APPEND, 32'h7fff_ffff);
    offer_word(OP_APPEND, 32'h7fff_ffff);
    // duplicate: only the lower copy goes, the tail moves into its slot
    offer_word(OP_REMOVE, 32'h7fff_ffff);
    offer_word(OP_REMOVE, 32'h0001_2345);
    // the tail entry itself
    offer_word(OP_REMOVE, 32'h7fff_ffff);
    // drain down to empty, then one more remove on the empty store
    offer_word(OP_REMOVE, 32'h8000_0000);
    offer_word(OP_REMOVE, 32'h0000_0000);
    offer_word(OP_REMOVE, 32'h0000_0001);
    offer_word(OP_REMOVE, 32'hffff_ffff);
    offer_word(OP_REMOVE, 32'h8000_0000);
    offer_word(OP_REMOVE, 32'h8000_0000);
    // first append into the empty store leaves sorted alone, a lower one clears it
    offer_word(OP_APPEND, 32'h5555_5555);
    offer_word(OP_APPEND, 32'haaaa_aaaa);
    offer_word(OP_APPEND, 32'h5555_5555);
    offer_word(OP_REMOVE, 32'h5555_5555);
    offer_word(OP_REMOVE, 32'haaaa_aaaa);

    // random mix, mostly pool keys; the store stays fairly small here
    for (n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 50 == 0) tx_calm = ($urandom_range(0, 2) == 0);
      op = ($urandom_range(0, 99) < 45) ? OP_APPEND : OP_REMOVE;
      k  = ($urandom_range(0, 3) == 0) ? $urandom : key_pool[$urandom_range(0, 15)];
      offer_word(op, k);
    end

    // grow the store with appends only
    for (n = 0; n < GROW_WORDS; n++) begin
      if (n % 50 == 0) tx_calm = ($urandom_range(0, 2) == 0);
      k = ($urandom_range(0, 1) == 0) ? $urandom : key_pool[$urandom_range(0, 15)];
      offer_word(OP_APPEND, k);
    end

    // larger store: long scans and swaps deep in the array
    for (n = 0; n < DEEP_WORDS; n++) begin
      op = ($urandom_range(0, 2) == 0) ? OP_APPEND : OP_REMOVE;
      k  = ($urandom_range(0, 4) == 0) ? $urandom : key_pool[$urandom_range(0, 15)];
      offer_word(op, k);
    end

    push <= 1'b0;
    // wait for an edge so the last accepted word shows up in the open count
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
